@@ hw/rtl/qte_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_pkg
// Shared widths, types and the arctangent table of the quaternion to Euler
// angle pipeline.
// ----------------------------------------------------------------------------
package qte_pkg;

   localparam int ITER_DEFAULT = 16;
   localparam int ITER_MAX     = 24;
   localparam int TW           = 34;   // term width, 30 fraction bits
   localparam int XW           = 37;   // CORDIC vector width
   localparam int AW           = 34;   // angle accumulator, 2^31 = pi
   localparam int RW           = 18;   // rounded angle before final trim
   localparam int SQW          = 62;   // square root working width
   localparam int SQRT_STAGES  = 31;   // one root bit per stage
   localparam int MAGW         = 31;   // magnitude of the pitch term

   typedef logic signed [TW-1:0] term_type;

   typedef struct packed {
      term_type t0;
      term_type t1;
      term_type t2;
      term_type t3;
      term_type t4;
   } side_type;

   localparam logic [31:0] ATAN_TABLE [ITER_MAX] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

endpackage

@@ hw/rtl/qte_products.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_products
// Three stages: component products, the five angle terms with the pitch
// clamp, and the square root radicand 1 - t2^2.
// ----------------------------------------------------------------------------
module qte_products
   import qte_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  logic signed [15:0] quat_w,
   input  logic signed [15:0] quat_x,
   input  logic signed [15:0] quat_y,
   input  logic signed [15:0] quat_z,
   output logic               out_valid,
   output side_type           out_side,
   output logic [SQW-1:0]     out_radicand
);

   localparam term_type       ONE_Q30  = term_type'(TW'(1) << 30);
   localparam term_type       NEG_Q30  = term_type'(-(TW'(1) << 30));
   localparam logic [SQW-1:0] RAD_ONE  = SQW'(1) << 60;

   logic signed [31:0] wx_ff, yz_ff, wy_ff, zx_ff, wz_ff, xy_ff, xx_ff, yy_ff, zz_ff;
   logic               v0_ff, v1_ff, v2_ff;
   side_type           side1_in, side1_ff, side2_ff;
   term_type           t2_raw;
   logic [MAGW-1:0]    mag_in, mag_ff;
   logic [SQW-1:0]     sq, rad_ff;

   always_comb begin
      side1_in.t0 = (term_type'(wx_ff) + term_type'(yz_ff)) <<< 1;
      side1_in.t1 = ONE_Q30 - ((term_type'(xx_ff) + term_type'(yy_ff)) <<< 1);
      t2_raw      = (term_type'(wy_ff) - term_type'(zx_ff)) <<< 1;
      side1_in.t3 = (term_type'(wz_ff) + term_type'(xy_ff)) <<< 1;
      side1_in.t4 = ONE_Q30 - ((term_type'(yy_ff) + term_type'(zz_ff)) <<< 1);
      if (t2_raw > ONE_Q30) begin
         side1_in.t2 = ONE_Q30;
      end else if (t2_raw < NEG_Q30) begin
         side1_in.t2 = NEG_Q30;
      end else begin
         side1_in.t2 = t2_raw;
      end
      mag_in = (side1_in.t2 < 0) ? MAGW'(-side1_in.t2) : MAGW'(side1_in.t2);
   end

   assign sq = mag_ff * mag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (advance) begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
      if (advance) begin
         wx_ff    <= 32'(quat_w * quat_x);
         yz_ff    <= 32'(quat_y * quat_z);
         wy_ff    <= 32'(quat_w * quat_y);
         zx_ff    <= 32'(quat_z * quat_x);
         wz_ff    <= 32'(quat_w * quat_z);
         xy_ff    <= 32'(quat_x * quat_y);
         xx_ff    <= 32'(quat_x * quat_x);
         yy_ff    <= 32'(quat_y * quat_y);
         zz_ff    <= 32'(quat_z * quat_z);
         side1_ff <= side1_in;
         mag_ff   <= mag_in;
         side2_ff <= side1_ff;
         rad_ff   <= RAD_ONE - sq;
      end
   end

   assign out_valid    = v2_ff;
   assign out_side     = side2_ff;
   assign out_radicand = rad_ff;

endmodule

@@ hw/rtl/qte_sqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_sqrt
// Pipelined integer square root, one root bit per stage, with the angle
// terms carried alongside.
// ----------------------------------------------------------------------------
module qte_sqrt
   import qte_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  logic            in_valid,
   input  side_type        in_side,
   input  logic [SQW-1:0]  in_radicand,
   output logic            out_valid,
   output side_type        out_side,
   output logic [MAGW-1:0] out_root
);

   logic [SQW-1:0] rem_ff  [SQRT_STAGES];
   logic [SQW-1:0] res_ff  [SQRT_STAGES];
   side_type       side_ff [SQRT_STAGES];
   logic           valid_ff [SQRT_STAGES];

   for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
      localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (SQRT_STAGES - 1 - k));
      logic [SQW-1:0] rem_prev, res_prev, trial, rem_in, res_in;
      side_type       side_prev;
      logic           valid_prev;

      if (k == 0) begin : g_first
         assign rem_prev   = in_radicand;
         assign res_prev   = '0;
         assign side_prev  = in_side;
         assign valid_prev = in_valid;
      end else begin : g_next
         assign rem_prev   = rem_ff[k-1];
         assign res_prev   = res_ff[k-1];
         assign side_prev  = side_ff[k-1];
         assign valid_prev = valid_ff[k-1];
      end

      always_comb begin
         trial = res_prev + BIT;
         if (rem_prev >= trial) begin
            rem_in = rem_prev - trial;
            res_in = (res_prev >> 1) + BIT;
         end else begin
            rem_in = rem_prev;
            res_in = res_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= valid_prev;
         end
         if (advance) begin
            rem_ff[k]  <= rem_in;
            res_ff[k]  <= res_in;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[SQRT_STAGES-1];
   assign out_side  = side_ff[SQRT_STAGES-1];
   assign out_root  = res_ff[SQRT_STAGES-1][MAGW-1:0];

endmodule

@@ hw/rtl/qte_cordic.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_cordic
// Pipelined vectoring CORDIC atan2: quadrant pre-rotation, one
// micro-rotation per stage, then rounding to binary angle units.
// ----------------------------------------------------------------------------
module qte_cordic
   import qte_pkg::*;
#(
   parameter int ITERATIONS = ITER_DEFAULT
)(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  term_type             vec_y,
   input  term_type             vec_x,
   output logic                 out_valid,
   output logic signed [RW-1:0] out_angle
);

   localparam int N = (ITERATIONS < ITER_MAX) ? ITERATIONS : ITER_MAX;
   localparam logic signed [AW-1:0] QUARTER = AW'(1) << 30;

   logic signed [XW-1:0] px_in, py_in, px_ff, py_ff;
   logic signed [AW-1:0] pa_in, pa_ff;
   logic                 pz_ff, pv_ff;

   logic signed [XW-1:0] x_ff [N];
   logic signed [XW-1:0] y_ff [N];
   logic signed [AW-1:0] a_ff [N];
   logic                 z_ff [N];
   logic                 v_ff [N];

   logic signed [AW-1:0] rsum;
   logic signed [RW-1:0] angle_ff;
   logic                 valid_ff;

   always_comb begin
      px_in = XW'(vec_x);
      py_in = XW'(vec_y);
      pa_in = '0;
      if (vec_x < 0) begin
         if (vec_y >= 0) begin
            pa_in = QUARTER;
            px_in = XW'(vec_y);
            py_in = -XW'(vec_x);
         end else begin
            pa_in = -QUARTER;
            px_in = -XW'(vec_y);
            py_in = XW'(vec_x);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else if (advance) begin
         pv_ff <= in_valid;
      end
      if (advance) begin
         px_ff <= px_in;
         py_ff <= py_in;
         pa_ff <= pa_in;
         pz_ff <= (vec_x == 0) && (vec_y == 0);
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_iter
      localparam logic signed [AW-1:0] STEP = $signed({2'b00, ATAN_TABLE[i]});
      logic signed [XW-1:0] x_prev, y_prev, dx, dy;
      logic signed [AW-1:0] a_prev;
      logic                 z_prev, v_prev;

      if (i == 0) begin : g_first
         assign x_prev = px_ff;
         assign y_prev = py_ff;
         assign a_prev = pa_ff;
         assign z_prev = pz_ff;
         assign v_prev = pv_ff;
      end else begin : g_next
         assign x_prev = x_ff[i-1];
         assign y_prev = y_ff[i-1];
         assign a_prev = a_ff[i-1];
         assign z_prev = z_ff[i-1];
         assign v_prev = v_ff[i-1];
      end

      assign dx = y_prev >>> i;
      assign dy = x_prev >>> i;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (advance) begin
            v_ff[i] <= v_prev;
         end
         if (advance) begin
            z_ff[i] <= z_prev;
            if (y_prev > 0) begin
               x_ff[i] <= x_prev + dx;
               y_ff[i] <= y_prev - dy;
               a_ff[i] <= a_prev + STEP;
            end else begin
               x_ff[i] <= x_prev - dx;
               y_ff[i] <= y_prev + dy;
               a_ff[i] <= a_prev - STEP;
            end
         end
      end
   end

   assign rsum = (a_ff[N-1] + AW'(32768)) >>> 16;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= v_ff[N-1];
      end
      if (advance) begin
         angle_ff <= z_ff[N-1] ? '0 : RW'(rsum);
      end
   end

   assign out_valid = valid_ff;
   assign out_angle = angle_ff;

endmodule

@@ hw/rtl/quaternion_to_euler_angles.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// Q1.15 quaternion to z-y-x roll, pitch and yaw binary angles.
//
//   channel   ports                                   dir
//   request   req_valid req_stall req_quat_w/x/y/z    in
//   response  rsp_valid rsp_stall rsp_roll/pitch/yaw  out
//
// One transfer per cycle while the response is not stalled. The stages
// (ANGLE_ITERATIONS capped at 24) are three product stages, 31 square root
// stages, CORDIC pre-rotation, one stage per micro-rotation, rounding and
// the response register. Reset clears all valid bits. A stalled response
// holds the whole pipeline; req_stall follows rsp_valid and rsp_stall.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles
   import qte_pkg::*;
#(
   parameter int ANGLE_ITERATIONS = ITER_DEFAULT
)(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_quat_w,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_roll_angle,
   output logic signed [15:0] rsp_pitch_angle,
   output logic signed [15:0] rsp_yaw_angle
);

   localparam logic signed [RW-1:0] PITCH_MAX = RW'(16384);
   localparam logic signed [RW-1:0] PITCH_MIN = -RW'(16384);

   logic               advance;
   logic               prod_valid, sq_valid;
   side_type           prod_side, sq_side;
   logic [SQW-1:0]     radicand;
   logic [MAGW-1:0]    root;
   logic               roll_valid, pitch_valid, yaw_valid;
   logic signed [RW-1:0] roll_a, pitch_a, yaw_a;
   term_type           root_term;

   logic               rsp_valid_ff;
   logic signed [15:0] roll_ff, pitch_ff, yaw_ff;
   logic signed [15:0] pitch_in;

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;
   assign root_term = $signed({3'b000, root});

   qte_products u_products (
      .clock, .reset, .advance,
      .in_valid     (req_valid),
      .quat_w       (req_quat_w),
      .quat_x       (req_quat_x),
      .quat_y       (req_quat_y),
      .quat_z       (req_quat_z),
      .out_valid    (prod_valid),
      .out_side     (prod_side),
      .out_radicand (radicand)
   );

   qte_sqrt u_sqrt (
      .clock, .reset, .advance,
      .in_valid    (prod_valid),
      .in_side     (prod_side),
      .in_radicand (radicand),
      .out_valid   (sq_valid),
      .out_side    (sq_side),
      .out_root    (root)
   );

   qte_cordic #(.ITERATIONS(ANGLE_ITERATIONS)) u_roll (
      .clock, .reset, .advance,
      .in_valid (sq_valid), .vec_y (sq_side.t0), .vec_x (sq_side.t1),
      .out_valid (roll_valid), .out_angle (roll_a)
   );

   qte_cordic #(.ITERATIONS(ANGLE_ITERATIONS)) u_pitch (
      .clock, .reset, .advance,
      .in_valid (sq_valid), .vec_y (sq_side.t2), .vec_x (root_term),
      .out_valid (pitch_valid), .out_angle (pitch_a)
   );

   qte_cordic #(.ITERATIONS(ANGLE_ITERATIONS)) u_yaw (
      .clock, .reset, .advance,
      .in_valid (sq_valid), .vec_y (sq_side.t3), .vec_x (sq_side.t4),
      .out_valid (yaw_valid), .out_angle (yaw_a)
   );

   always_comb begin
      if (pitch_a > PITCH_MAX) begin
         pitch_in = 16'(PITCH_MAX);
      end else if (pitch_a < PITCH_MIN) begin
         pitch_in = 16'(PITCH_MIN);
      end else begin
         pitch_in = pitch_a[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= roll_valid;
      end
      if (advance) begin
         roll_ff  <= roll_a[15:0];
         pitch_ff <= pitch_in;
         yaw_ff   <= yaw_a[15:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_roll_angle  = roll_ff;
   assign rsp_pitch_angle = pitch_ff;
   assign rsp_yaw_angle   = yaw_ff;

   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pitch_angle <= 16'sd16384 && rsp_pitch_angle >= -16'sd16384))
      else $error("pitch angle out of range");

   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      (roll_valid == pitch_valid) && (roll_valid == yaw_valid))
      else $error("angle lanes out of step");

   a_stall_follows: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("request stall mismatch");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the quaternion to Euler angle pipeline. A queue of
// quaternions (corner values, unit rotations, random noise) feeds a clocked
// driver; a clocked monitor compares each response transfer against a
// bit-exact fixed point predictor with CORDIC arctangent. Both sides idle in
// random bursts; the last part of the run streams at full rate.
// ----------------------------------------------------------------------------
module testbench;
   import qte_pkg::*;

   localparam int ITER      = 16;
   localparam int LATENCY   = 37 + ITER;
   localparam int N_RANDOM  = 1700;
   localparam int CYCLE_CAP = 400000;

   typedef struct {
      logic signed [15:0] w, x, y, z;
   } quat_type;

   typedef struct {
      logic signed [15:0] roll, pitch, yaw;
   } angles_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [15:0] req_quat_w = '0, req_quat_x = '0, req_quat_y = '0, req_quat_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_roll_angle, rsp_pitch_angle, rsp_yaw_angle;

   quat_type   pending_quats[$];
   angles_type expected_angles[$];
   int         mismatches = 0;
   int         cycle_count = 0;
   int         send_idle = 0, recv_idle = 0;
   bit         calm = 1'b0;

   quaternion_to_euler_angles #(.ANGLE_ITERATIONS(ITER)) uut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint root_floor(longint v);
      longint res = 0, lo, hi, mid;
      lo = 0;
      hi = 64'd1 << 31;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         if (mid * mid <= v) lo = mid;
         else hi = mid - 1;
      end
      res = lo;
      return res;
   endfunction

   function automatic longint cordic_angle(longint yin, longint xin);
      longint ang = 0, xv = xin, yv = yin, tmp, dx, dy;
      int n;
      n = (ITER < ITER_MAX) ? ITER : ITER_MAX;
      if (xv == 0 && yv == 0) return 0;
      if (xv < 0) begin
         if (yv >= 0) begin
            ang = 64'sd1 << 30;
            tmp = xv; xv = yv; yv = -tmp;
         end else begin
            ang = -(64'sd1 << 30);
            tmp = xv; xv = -yv; yv = tmp;
         end
      end
      for (int i = 0; i < n; i++) begin
         dx = floor_shift(yv, i);
         dy = floor_shift(xv, i);
         if (yv > 0) begin
            xv += dx; yv -= dy; ang += longint'(ATAN_TABLE[i]);
         end else begin
            xv -= dx; yv += dy; ang -= longint'(ATAN_TABLE[i]);
         end
      end
      return floor_shift(ang + 32768, 16);
   endfunction

   function automatic angles_type euler_angles(quat_type q);
      longint w, x, y, z, ysq, t0, t1, t2, t3, t4, mag, c, p;
      angles_type a;
      w = q.w; x = q.x; y = q.y; z = q.z;
      ysq = y * y;
      t0 = 2 * (w * x + y * z);
      t1 = (64'sd1 << 30) - 2 * (x * x + ysq);
      t2 = 2 * (w * y - z * x);
      t3 = 2 * (w * z + x * y);
      t4 = (64'sd1 << 30) - 2 * (ysq + z * z);
      if (t2 > (64'sd1 << 30)) t2 = 64'sd1 << 30;
      if (t2 < -(64'sd1 << 30)) t2 = -(64'sd1 << 30);
      mag = t2 < 0 ? -t2 : t2;
      c = root_floor((64'sd1 << 60) - mag * mag);
      p = cordic_angle(t2, c);
      if (p > 16384) p = 16384;
      if (p < -16384) p = -16384;
      a.roll  = 16'(cordic_angle(t0, t1));
      a.pitch = 16'(p);
      a.yaw   = 16'(cordic_angle(t3, t4));
      return a;
   endfunction

   task automatic report(string msg);
      $display("mismatch: %s at cycle %0d", msg, cycle_count);
      mismatches++;
   endtask

   function automatic quat_type make_quat(int w, int x, int y, int z);
      quat_type q;
      q.w = 16'(w); q.x = 16'(x); q.y = 16'(y); q.z = 16'(z);
      return q;
   endfunction

   function automatic void queue_quat(quat_type q);
      pending_quats.insert(pending_quats.size(), q);
   endfunction

   function automatic logic signed [15:0] rand_field();
      case ($urandom_range(0, 5))
         0: return 16'(32767 - $urandom_range(0, 3));
         1: return 16'(-32768 + $urandom_range(0, 3));
         2: return 16'($urandom_range(0, 8) - 4);
         default: return 16'($urandom);
      endcase
   endfunction

   // unit quaternion from random direction, normalized in real arithmetic
   function automatic quat_type rand_unit();
      real v[4], n;
      quat_type q;
      n = 0.0;
      for (int i = 0; i < 4; i++) begin
         v[i] = real'($signed($urandom_range(0, 65534)) - 32767);
         n += v[i] * v[i];
      end
      n = $sqrt(n);
      if (n < 1.0) n = 1.0;
      q.w = 16'($rtoi(v[0] / n * 32767.0));
      q.x = 16'($rtoi(v[1] / n * 32767.0));
      q.y = 16'($rtoi(v[2] / n * 32767.0));
      q.z = 16'($rtoi(v[3] / n * 32767.0));
      return q;
   endfunction

   initial begin
      quat_type q;
      queue_quat(make_quat(32767, 0, 0, 0));
      queue_quat(make_quat(0, 0, 0, 0));
      queue_quat(make_quat(-32768, -32768, -32768, -32768));
      queue_quat(make_quat(32767, 32767, 32767, 32767));
      queue_quat(make_quat(0, 32767, 0, 0));
      queue_quat(make_quat(0, 0, 32767, 0));
      queue_quat(make_quat(0, 0, 0, 32767));
      queue_quat(make_quat(0, -32768, 0, 0));
      queue_quat(make_quat(23170, 0, 23170, 0));
      queue_quat(make_quat(23170, 0, -23170, 0));
      queue_quat(make_quat(23170, 0, 23171, 0));
      queue_quat(make_quat(32767, 0, 32767, 0));
      queue_quat(make_quat(-32768, 0, 32767, 0));
      queue_quat(make_quat(0, 0, 0, -32768));
      queue_quat(make_quat(23170, 23170, 0, 0));
      queue_quat(make_quat(23170, -23170, 0, 0));
      queue_quat(make_quat(-1, 1, -1, 1));
      queue_quat(make_quat(16384, 16384, 16384, 16384));
      queue_quat(make_quat(100, 0, 0, 0));
      queue_quat(make_quat(32767, 1, -1, 0));
      for (int i = 0; i < N_RANDOM; i++) begin
         if ($urandom_range(0, 3) != 0) q = rand_unit();
         else begin
            q.w = rand_field(); q.x = rand_field();
            q.y = rand_field(); q.z = rand_field();
         end
         queue_quat(q);
      end
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) expected_angles.insert(expected_angles.size(), euler_angles(
            make_quat(req_quat_w, req_quat_x, req_quat_y, req_quat_z)));
         if (send_idle > 0) begin
            send_idle <= send_idle - 1;
            req_valid <= 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            send_idle <= $urandom_range(1, 18) - 1;
            req_valid <= 1'b0;
         end else if (pending_quats.size() > 0) begin
            q_send();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   task automatic q_send();
      quat_type q;
      q = pending_quats.pop_front();
      req_valid  <= 1'b1;
      req_quat_w <= q.w;
      req_quat_x <= q.x;
      req_quat_y <= q.y;
      req_quat_z <= q.z;
   endtask

   // monitor and response stall
   always @(posedge clock) begin
      angles_type e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_angles.size() == 0) begin
               report("unexpected response transfer");
            end else begin
               e = expected_angles.pop_front();
               if (rsp_roll_angle !== e.roll)
                  report($sformatf("roll got %0d expected %0d", rsp_roll_angle, e.roll));
               if (rsp_pitch_angle !== e.pitch)
                  report($sformatf("pitch got %0d expected %0d", rsp_pitch_angle, e.pitch));
               if (rsp_yaw_angle !== e.yaw)
                  report($sformatf("yaw got %0d expected %0d", rsp_yaw_angle, e.yaw));
            end
         end
         if (recv_idle > 0) begin
            recv_idle <= recv_idle - 1;
            rsp_stall <= 1'b1;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            recv_idle <= $urandom_range(1, 18) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (pending_quats.size() < 300) calm <= 1'b1;
      if (cycle_count >= CYCLE_CAP) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      wait (pending_quats.size() == 0);
      @(posedge clock);
      while (req_valid || expected_angles.size() > 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
      if (mismatches == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/qte_pkg.sv
hw/rtl/qte_products.sv
hw/rtl/qte_sqrt.sv
hw/rtl/qte_cordic.sv
hw/rtl/quaternion_to_euler_angles.sv
test/testbench.sv
